// ===== rtl/npie_pkg.sv =====
// ----------------------------------------------------------------------------
// NVMe protection info engine package
// Shared types, register indexes, verdict codes and CRC byte-update functions.
// ----------------------------------------------------------------------------
package npie_pkg;

  localparam int MAX_PI_BYTES_DEF = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] REG_BLOCK_BYTES = 3'd0;
  localparam logic [2:0] REG_METADATA_BYTES = 3'd1;
  localparam logic [2:0] REG_GUARD_FORMAT = 3'd2;
  localparam logic [2:0] REG_LAYOUT_MODE = 3'd3;
  localparam logic [2:0] REG_PROTECTION_TYPE = 3'd4;
  localparam logic [2:0] REG_CHECK_ENABLES = 3'd5;
  localparam logic [2:0] REG_FIRST_REF_TAG = 3'd6;
  localparam logic [2:0] REG_APP_TAG_AND_MASK = 3'd7;

  localparam logic [3:0] VERDICT_NONE = 4'd0;
  localparam logic [3:0] VERDICT_GENERATED = 4'd1;
  localparam logic [3:0] VERDICT_PASS = 4'd2;
  localparam logic [3:0] VERDICT_GUARD_BAD = 4'd3;
  localparam logic [3:0] VERDICT_APP_BAD = 4'd4;
  localparam logic [3:0] VERDICT_REF_BAD = 4'd5;
  localparam logic [3:0] VERDICT_ESCAPED = 4'd6;
  localparam logic [3:0] VERDICT_UNCHECKED = 4'd7;
  localparam logic [3:0] VERDICT_CONFIG_BAD = 4'd8;

  localparam logic [15:0] CRC16_POLY = 16'h8BB7;
  localparam logic [63:0] CRC64_POLY = 64'h9A6C9329AC4BC9B5;

  // Configuration as seen by the front and back parts.
  typedef struct packed {
    logic [15:0] block_bytes;
    logic [7:0]  metadata_bytes;
    logic        guard_format;
    logic [1:0]  layout_mode;
    logic [1:0]  protection_type;
    logic [2:0]  check_enables;
    logic [31:0] first_ref_tag;
    logic [31:0] app_tag_and_mask;
  } cfg_t;

  // One classified word handed from the front to the back.
  typedef struct packed {
    logic [7:0]  data;
    logic        command_start;
    logic        kind;
    logic        valid_cfg;
    logic        in_crc;
    logic        in_pi;
    logic [3:0]  pi_index;
    logic        block_end;
  } work_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC16_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [63:0] crc64_byte(input logic [63:0] acc, input logic [7:0] b);
    logic [63:0] c;
    c = ~acc ^ {56'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC64_POLY) : (c >> 1);
    end
    return ~c;
  endfunction

endpackage

// ===== rtl/npie_front.sv =====
// ----------------------------------------------------------------------------
// NVMe protection info engine front end
// Tracks the byte position within a block and classifies each stream word.
// ----------------------------------------------------------------------------
module npie_front #(
  parameter int MAX_PI_BYTES = npie_pkg::MAX_PI_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  npie_pkg::cfg_t      cfg,
  input  logic                take,
  input  logic                kind,
  input  logic [7:0]          in_byte,
  input  logic                command_start,
  output npie_pkg::work_t     work
);

  logic [16:0] byte_position;
  logic [16:0] pos;
  logic        wide;
  logic [4:0]  pi;
  logic [16:0] len;
  logic [16:0] start;
  logic [16:0] rel;
  logic        valid_cfg;
  logic [15:0] unit_mask;
  logic        end_now;

  always_comb begin
    wide = cfg.guard_format;
    pi = wide ? 5'd16 : 5'd8;
    unit_mask = wide ? 16'h0FFF : 16'h01FF;
    valid_cfg = 1'b1;
    if (pi > 5'(MAX_PI_BYTES)) valid_cfg = 1'b0;
    if ({3'd0, cfg.metadata_bytes} < {6'd0, pi}) valid_cfg = 1'b0;
    if (cfg.layout_mode[0]) begin
      if (cfg.block_bytes < {8'd0, cfg.metadata_bytes}) valid_cfg = 1'b0;
    end else begin
      if (cfg.block_bytes == 16'd0 || (cfg.block_bytes & unit_mask) != 16'd0) valid_cfg = 1'b0;
    end
    if (cfg.protection_type == 2'd3 && cfg.check_enables[2]) valid_cfg = 1'b0;
    len = {1'b0, cfg.block_bytes} + (cfg.layout_mode[0] ? 17'd0 : {9'd0, cfg.metadata_bytes});
    if (cfg.layout_mode[0]) begin
      start = cfg.layout_mode[1] ? {1'b0, cfg.block_bytes - {8'd0, cfg.metadata_bytes}}
                                 : {1'b0, cfg.block_bytes - {11'd0, pi}};
    end else begin
      start = {1'b0, cfg.block_bytes} +
              (cfg.layout_mode[1] ? 17'd0 : {9'd0, cfg.metadata_bytes - {3'd0, pi}});
    end
    pos = command_start ? 17'd0 : byte_position;
    rel = pos - start;
    end_now = ({1'b0, pos} + 18'd1) >= {1'b0, len};
    work.data = in_byte;
    work.command_start = command_start;
    work.kind = kind;
    work.valid_cfg = valid_cfg;
    work.in_crc = valid_cfg && (pos < start);
    work.in_pi = valid_cfg && (pos >= start) && (rel < {12'd0, pi});
    work.pi_index = rel[3:0];
    work.block_end = end_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (take) begin
      byte_position <= end_now ? 17'd0 : pos + 17'd1;
    end
  end

endmodule

// ===== rtl/npie_queue.sv =====
// ----------------------------------------------------------------------------
// NVMe protection info engine work queue
// Small queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module npie_queue #(
  parameter int DEPTH = npie_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  npie_pkg::work_t wdata,
  output logic            full,
  input  logic            rd,
  output npie_pkg::work_t rdata,
  output logic            empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  npie_pkg::work_t mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;

  assign full = count == (AW+1)'(DEPTH);
  assign empty = count == '0;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd && !empty) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
    end
  end

endmodule

// ===== rtl/npie_back.sv =====
// ----------------------------------------------------------------------------
// NVMe protection info engine back end
// Runs the guard CRC, inserts or captures protection bytes, forms verdicts.
// ----------------------------------------------------------------------------
module npie_back #(
  parameter int MAX_PI_BYTES = npie_pkg::MAX_PI_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  npie_pkg::cfg_t  cfg,
  input  npie_pkg::work_t work,
  input  logic            work_valid,
  output logic            work_take,
  output logic            out_valid,
  input  logic            out_take,
  output logic [7:0]      out_byte_q,
  output logic            block_end_q,
  output logic [3:0]      verdict_q,
  output logic [31:0]     block_offset_q
);

  logic [63:0] crc_accumulator;
  logic [31:0] block_counter;
  logic        command_failed;
  logic        command_kind;
  logic [7:0]  captured_field [MAX_PI_BYTES];

  logic [63:0] crc_cur;
  logic [31:0] cnt_cur;
  logic        failed_cur;
  logic        kind_cur;
  logic        wide;
  logic [63:0] crc_next;
  logic [7:0]  ob;
  logic [63:0] g;
  logic [31:0] ref_gen;
  logic [47:0] ref_wide;
  logic [3:0]  k;
  logic [7:0]  fld [16];
  logic [63:0] guard_st;
  logic [15:0] app_st;
  logic [47:0] ref_st;
  logic [63:0] calc;
  logic [15:0] mask;
  logic [31:0] exp_ref;
  logic [3:0]  vb;
  logic [3:0]  verdict;
  logic        fail_set;

  assign work_take = work_valid && (!out_valid || out_take);

  always_comb begin
    wide = cfg.guard_format;
    crc_cur = work.command_start ? 64'd0 : crc_accumulator;
    cnt_cur = work.command_start ? 32'd0 : block_counter;
    failed_cur = work.command_start ? 1'b0 : command_failed;
    kind_cur = work.command_start ? work.kind : command_kind;
    k = work.pi_index;
    crc_next = wide ? npie_pkg::crc64_byte(crc_cur, work.data)
                    : {48'd0, npie_pkg::crc16_byte(crc_cur[15:0], work.data)};
    g = wide ? crc_cur : {48'd0, crc_cur[15:0]};
    ref_gen = cfg.first_ref_tag + ((cfg.protection_type == 2'd3) ? 32'd0 : cnt_cur);
    ref_wide = {16'd0, ref_gen};
    ob = work.data;
    if (work.in_pi && !kind_cur) begin
      if (wide) begin
        if (k < 4'd8) begin
          if (cfg.check_enables[0]) ob = g[8*(7-k) +: 8];
        end else if (k < 4'd10) begin
          if (cfg.check_enables[1]) ob = cfg.app_tag_and_mask[8*(9-k) +: 8];
        end else if (cfg.check_enables[2]) begin
          ob = ref_wide[8*(15-k) +: 8];
        end
      end else begin
        if (k < 4'd2) begin
          if (cfg.check_enables[0]) ob = g[8*(1-k[0]) +: 8];
        end else if (k < 4'd4) begin
          if (cfg.check_enables[1]) ob = cfg.app_tag_and_mask[8*(3-k) +: 8];
        end else if (cfg.check_enables[2]) begin
          ob = ref_gen[8*(7-k) +: 8];
        end
      end
    end
    // Field view including the byte being captured now.
    for (int i = 0; i < 16; i++) begin
      fld[i] = (i < MAX_PI_BYTES) ? captured_field[i % MAX_PI_BYTES] : 8'd0;
      if (work.in_pi && k == 4'(i)) fld[i] = work.data;
    end
    if (wide) begin
      guard_st = {fld[0], fld[1], fld[2], fld[3], fld[4], fld[5], fld[6], fld[7]};
      app_st = {fld[8], fld[9]};
      ref_st = {fld[10], fld[11], fld[12], fld[13], fld[14], fld[15]};
    end else begin
      guard_st = {48'd0, fld[0], fld[1]};
      app_st = {fld[2], fld[3]};
      ref_st = {16'd0, fld[4], fld[5], fld[6], fld[7]};
    end
    calc = g;
    mask = cfg.app_tag_and_mask[31:16];
    exp_ref = cfg.first_ref_tag + cnt_cur;
    if ((cfg.protection_type == 2'd1 || cfg.protection_type == 2'd2) && app_st == 16'hFFFF) begin
      vb = npie_pkg::VERDICT_ESCAPED;
    end else if (cfg.protection_type == 2'd3 && app_st == 16'hFFFF &&
                 ref_st == (wide ? 48'hFFFFFFFFFFFF : 48'h0000FFFFFFFF)) begin
      vb = npie_pkg::VERDICT_ESCAPED;
    end else if (cfg.check_enables[0] && guard_st != calc) begin
      vb = npie_pkg::VERDICT_GUARD_BAD;
    end else if (cfg.check_enables[1] &&
                 (app_st & mask) != (cfg.app_tag_and_mask[15:0] & mask)) begin
      vb = npie_pkg::VERDICT_APP_BAD;
    end else if (cfg.check_enables[2] &&
                 (cfg.protection_type == 2'd1 || cfg.protection_type == 2'd2) &&
                 ref_st != {16'd0, exp_ref}) begin
      vb = npie_pkg::VERDICT_REF_BAD;
    end else begin
      vb = npie_pkg::VERDICT_PASS;
    end
    verdict = npie_pkg::VERDICT_NONE;
    fail_set = 1'b0;
    if (work.block_end) begin
      if (!work.valid_cfg) verdict = npie_pkg::VERDICT_CONFIG_BAD;
      else if (!kind_cur) verdict = npie_pkg::VERDICT_GENERATED;
      else if (failed_cur) verdict = npie_pkg::VERDICT_UNCHECKED;
      else begin
        verdict = vb;
        fail_set = (vb == npie_pkg::VERDICT_GUARD_BAD) || (vb == npie_pkg::VERDICT_APP_BAD) ||
                   (vb == npie_pkg::VERDICT_REF_BAD);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (work_take && work.in_pi) begin
      captured_field[k] <= work.data;
    end
    if (work_take) begin
      out_byte_q <= ob;
      block_end_q <= work.block_end;
      verdict_q <= verdict;
      block_offset_q <= cnt_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accumulator <= '0;
      block_counter <= '0;
      command_failed <= 1'b0;
      command_kind <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (work_take) begin
        out_valid <= 1'b1;
        command_kind <= kind_cur;
        command_failed <= failed_cur | fail_set;
        if (work.block_end) begin
          crc_accumulator <= '0;
          block_counter <= cnt_cur + 32'd1;
        end else begin
          crc_accumulator <= work.in_crc ? crc_next : crc_cur;
          block_counter <= cnt_cur;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/nvme_protection_info_engine.sv =====
// Path: a pushed word passes the queue, then the result register, before it can be popped.
// Throughput: one word per cycle while results are popped; a held result stalls the back end.
// Reset: synchronous active-high rst empties the queue and result register, clears the
// CRC, block position, block count, failure flag and command kind, and loads the register
// reset values. The captured protection bytes are not cleared.
// ----------------------------------------------------------------------------
// NVMe protection info engine
// Generates or verifies T10 DIF style protection information on a byte stream.
// ----------------------------------------------------------------------------
module nvme_protection_info_engine #(
  parameter int MAX_PI_BYTES = npie_pkg::MAX_PI_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        kind,
  input  logic [7:0]  in_byte,
  input  logic        command_start,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        block_end,
  output logic [3:0]  verdict,
  output logic [31:0] block_offset,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers: the user must write them only while the block is idle; unchecked.
  npie_pkg::cfg_t  cfg;
  npie_pkg::work_t front_work;
  npie_pkg::work_t q_work;
  logic            q_empty;
  logic            back_take;
  logic            out_valid;
  logic            accept;

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_bytes <= 16'd512;
      cfg.metadata_bytes <= 8'd8;
      cfg.guard_format <= 1'b0;
      cfg.layout_mode <= 2'd0;
      cfg.protection_type <= 2'd1;
      cfg.check_enables <= 3'd7;
      cfg.first_ref_tag <= 32'd0;
      cfg.app_tag_and_mask <= 32'hFFFF0000;
    end else if (cfg_we) begin
      case (cfg_index)
        npie_pkg::REG_BLOCK_BYTES: cfg.block_bytes <= cfg_data[15:0];
        npie_pkg::REG_METADATA_BYTES: cfg.metadata_bytes <= cfg_data[7:0];
        npie_pkg::REG_GUARD_FORMAT: cfg.guard_format <= cfg_data[0];
        npie_pkg::REG_LAYOUT_MODE: cfg.layout_mode <= cfg_data[1:0];
        npie_pkg::REG_PROTECTION_TYPE: cfg.protection_type <= cfg_data[1:0];
        npie_pkg::REG_CHECK_ENABLES: cfg.check_enables <= cfg_data[2:0];
        npie_pkg::REG_FIRST_REF_TAG: cfg.first_ref_tag <= cfg_data;
        npie_pkg::REG_APP_TAG_AND_MASK: cfg.app_tag_and_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front end classifies each accepted word against the block layout.
  npie_front #(.MAX_PI_BYTES(MAX_PI_BYTES)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .take(accept), .kind(kind),
    .in_byte(in_byte), .command_start(command_start), .work(front_work)
  );

  // A short queue lets the front keep accepting while results wait for pop.
  npie_queue #(.DEPTH(npie_pkg::QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .wr(push), .wdata(front_work), .full(full),
    .rd(back_take), .rdata(q_work), .empty(q_empty)
  );

  // The back end owns the CRC, tags and verdicts and holds the result register.
  npie_back #(.MAX_PI_BYTES(MAX_PI_BYTES)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .work(q_work), .work_valid(!q_empty),
    .work_take(back_take), .out_valid(out_valid), .out_take(pop),
    .out_byte_q(out_byte), .block_end_q(block_end), .verdict_q(verdict),
    .block_offset_q(block_offset)
  );

  assign empty = !out_valid;

endmodule

// ===== rtl/npie_checker.sv =====
// ----------------------------------------------------------------------------
// NVMe protection info engine checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module npie_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_byte,
  input logic        block_end,
  input logic [3:0]  verdict,
  input logic [31:0] block_offset
);

  // A verdict appears only on the last word of a block.
  a_verdict_at_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && !block_end) |-> verdict == npie_pkg::VERDICT_NONE)
    else $error("verdict off block end");

  // Every block end carries a verdict.
  a_end_has_verdict: assert property (@(posedge clk) disable iff (rst)
    (!empty && block_end) |-> verdict != npie_pkg::VERDICT_NONE)
    else $error("block end without verdict");

  // Within a block the offset does not move between consecutive results.
  a_offset_steady: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !block_end) ##1 (!empty && block_offset != 32'd0) |->
      block_offset == $past(block_offset))
    else $error("block offset changed inside a block");

  // A waiting result holds until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(verdict)))
    else $error("result changed while stalled");

endmodule

bind nvme_protection_info_engine npie_checker u_npie_checker (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop), .out_byte(out_byte),
  .block_end(block_end), .verdict(verdict), .block_offset(block_offset)
);

// ===== tb/sv/nvme_protection_info_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Protection info engine testbench
// Streams generate and verify commands through the engine under random
// configurations, idling and back pressure, and checks every output word
// against a cycle-free predictor of the protection info behavior.
// ----------------------------------------------------------------------------
module nvme_protection_info_engine_tb;

  localparam int STALL_LIMIT = 3000;
  localparam int PI_LIMIT = 16;
  localparam logic KIND_GENERATE = 1'b0;
  localparam logic KIND_VERIFY = 1'b1;
  // Ways of building one block of stimulus.
  localparam int STYLE_CLEAN = 0;
  localparam int STYLE_CORRUPT = 1;
  localparam int STYLE_ESCAPE = 2;
  localparam int STYLE_PARTIAL = 3;
  localparam logic [15:0] T10_POLY = 16'h8BB7;
  localparam logic [63:0] NVME64_POLY = 64'h9A6C9329AC4BC9B5;

  typedef struct {
    logic [7:0]  ob;
    logic        last;
    logic [3:0]  verdict;
    logic [31:0] offset;
  } word_exp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        kind = 1'b0;
  logic [7:0]  in_byte = 8'h00;
  logic        command_start = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        block_end;
  logic [3:0]  verdict;
  logic [31:0] block_offset;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Predictor copy of the engine's registers and stream state.
  npie_pkg::cfg_t m_cfg;
  logic [63:0] m_crc;
  logic [16:0] m_pos;
  logic [31:0] m_blk;
  logic [7:0]  m_cap [0:15];
  logic        m_failed;
  logic        m_kind;

  word_exp_t   pending_words[$];
  int          errors = 0;
  int          words_sent = 0;
  int          words_checked = 0;
  int          verdicts_seen = 0;
  int          settings_used = 0;
  int          stall_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_rx = 0;

  nvme_protection_info_engine dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind), .in_byte(in_byte),
    .command_start(command_start), .empty(empty), .pop(pop), .out_byte(out_byte),
    .block_end(block_end), .verdict(verdict), .block_offset(block_offset),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One byte of CRC-T10DIF (MSB first) or CRC-64/NVME (reflected, inverted).
  function automatic logic [63:0] crc_next(logic [63:0] acc, logic [7:0] b, logic wide);
    logic [15:0] c16;
    logic [63:0] c64;
    if (!wide) begin
      c16 = acc[15:0] ^ {b, 8'h00};
      repeat (8) c16 = c16[15] ? ({c16[14:0], 1'b0} ^ T10_POLY) : {c16[14:0], 1'b0};
      return {48'h0, c16};
    end
    c64 = ~acc ^ {56'h0, b};
    repeat (8) c64 = c64[0] ? ({1'b0, c64[63:1]} ^ NVME64_POLY) : {1'b0, c64[63:1]};
    return ~c64;
  endfunction

  function automatic int unsigned pi_len();
    return m_cfg.guard_format ? 16 : 8;
  endfunction

  // The block is only framed and checked when this holds.
  function automatic logic cfg_ok();
    int unsigned pi;
    int unsigned unit;
    pi = pi_len();
    unit = m_cfg.guard_format ? 4096 : 512;
    if (pi > PI_LIMIT || m_cfg.metadata_bytes < pi) return 1'b0;
    if (m_cfg.layout_mode[0]) begin
      if (m_cfg.block_bytes < m_cfg.metadata_bytes) return 1'b0;
    end else if (m_cfg.block_bytes == 0 || (m_cfg.block_bytes % unit) != 0) begin
      return 1'b0;
    end
    if (m_cfg.protection_type == 2'd3 && m_cfg.check_enables[2]) return 1'b0;
    return 1'b1;
  endfunction

  // Stream length of one block, metadata included.
  function automatic int unsigned stream_len();
    return m_cfg.block_bytes + (m_cfg.layout_mode[0] ? 0 : m_cfg.metadata_bytes);
  endfunction

  // Stream position of the first protection byte (valid configuration only).
  function automatic int unsigned field_start();
    int unsigned pi;
    pi = pi_len();
    if (m_cfg.layout_mode[0])
      return m_cfg.layout_mode[1] ? m_cfg.block_bytes - m_cfg.metadata_bytes
                                  : m_cfg.block_bytes - pi;
    return m_cfg.block_bytes + (m_cfg.layout_mode[1] ? 0 : m_cfg.metadata_bytes - pi);
  endfunction

  // Correct protection byte k for the current block: guard, app tag, ref tag.
  function automatic logic [7:0] pi_byte(int unsigned k);
    int unsigned gl;
    logic [63:0] guard;
    logic [63:0] ref_tag;
    gl = m_cfg.guard_format ? 8 : 2;
    guard = m_cfg.guard_format ? m_crc : {48'h0, m_crc[15:0]};
    ref_tag = {32'h0, m_cfg.first_ref_tag + (m_cfg.protection_type == 2'd3 ? 32'd0 : m_blk)};
    if (k < gl) return 8'(guard >> (8 * (gl - 1 - k)));
    if (k < gl + 2) return 8'(m_cfg.app_tag_and_mask[15:0] >> (8 * (gl + 1 - k)));
    return 8'(ref_tag >> (8 * (pi_len() - 1 - k)));
  endfunction

  function automatic logic [63:0] captured_be(int unsigned from, int unsigned count);
    logic [63:0] v;
    v = '0;
    for (int unsigned i = 0; i < count; i++) v = (v << 8) | m_cap[(from + i) & 15];
    return v;
  endfunction

  // Verify verdict of a finished block: escape first, then guard, app, ref.
  function automatic logic [3:0] verify_verdict();
    logic        wide;
    logic [63:0] guard;
    logic [63:0] app;
    logic [63:0] ref_tag;
    logic [63:0] ones;
    logic [15:0] mask;
    logic [31:0] want_ref;
    wide = m_cfg.guard_format;
    guard = wide ? captured_be(0, 8) : captured_be(0, 2);
    app = wide ? captured_be(8, 2) : captured_be(2, 2);
    ref_tag = wide ? captured_be(10, 6) : captured_be(4, 4);
    ones = wide ? 64'hFFFF_FFFF_FFFF : 64'hFFFF_FFFF;
    mask = m_cfg.app_tag_and_mask[31:16];
    want_ref = m_cfg.first_ref_tag + m_blk;
    if ((m_cfg.protection_type == 2'd1 || m_cfg.protection_type == 2'd2) && app == 64'hFFFF)
      return npie_pkg::VERDICT_ESCAPED;
    if (m_cfg.protection_type == 2'd3 && app == 64'hFFFF && ref_tag == ones)
      return npie_pkg::VERDICT_ESCAPED;
    if (m_cfg.check_enables[0] && guard != (wide ? m_crc : {48'h0, m_crc[15:0]}))
      return npie_pkg::VERDICT_GUARD_BAD;
    if (m_cfg.check_enables[1] && (app[15:0] & mask) != (m_cfg.app_tag_and_mask[15:0] & mask))
      return npie_pkg::VERDICT_APP_BAD;
    if (m_cfg.check_enables[2] && (m_cfg.protection_type == 2'd1 ||
        m_cfg.protection_type == 2'd2) && ref_tag != {32'h0, want_ref})
      return npie_pkg::VERDICT_REF_BAD;
    return npie_pkg::VERDICT_PASS;
  endfunction

  // A command start clears the block framing and latches the command kind.
  function automatic void start_command(logic k);
    m_pos = '0;
    m_crc = '0;
    m_blk = '0;
    m_failed = 1'b0;
    m_kind = k;
  endfunction

  // Advance the predictor by one accepted word and return its expected output.
  function automatic word_exp_t predict_word(logic k, logic [7:0] b, logic cs);
    word_exp_t   r;
    logic        ok;
    int unsigned p;
    int unsigned st;
    int unsigned kk;
    int unsigned gl;
    logic        ends;
    ok = cfg_ok();
    if (cs) start_command(k);
    p = m_pos;
    r.ob = b;
    r.verdict = npie_pkg::VERDICT_NONE;
    if (ok) begin
      st = field_start();
      if (p < st) begin
        m_crc = crc_next(m_crc, b, m_cfg.guard_format);
      end else if (p - st < pi_len()) begin
        kk = p - st;
        m_cap[kk & 15] = b;
        // Generate mode replaces only the fields whose check is enabled.
        if (m_kind == KIND_GENERATE) begin
          gl = m_cfg.guard_format ? 8 : 2;
          if (kk < gl) begin
            if (m_cfg.check_enables[0]) r.ob = pi_byte(kk);
          end else if (kk < gl + 2) begin
            if (m_cfg.check_enables[1]) r.ob = pi_byte(kk);
          end else if (m_cfg.check_enables[2]) begin
            r.ob = pi_byte(kk);
          end
        end
      end
    end
    ends = (p + 1) >= stream_len();
    r.last = ends;
    r.offset = m_blk;
    if (ends) begin
      if (!ok) r.verdict = npie_pkg::VERDICT_CONFIG_BAD;
      else if (m_kind == KIND_GENERATE) r.verdict = npie_pkg::VERDICT_GENERATED;
      else if (m_failed) r.verdict = npie_pkg::VERDICT_UNCHECKED;
      else begin
        r.verdict = verify_verdict();
        if (r.verdict inside {npie_pkg::VERDICT_GUARD_BAD, npie_pkg::VERDICT_APP_BAD,
                              npie_pkg::VERDICT_REF_BAD})
          m_failed = 1'b1;
      end
      m_pos = '0;
      m_crc = '0;
      m_blk = m_blk + 1;
    end else begin
      m_pos = 17'(p + 1);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving tasks
  // ---------------------------------------------------------------------------

  // Registers change only while the engine holds no work.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      npie_pkg::REG_BLOCK_BYTES: m_cfg.block_bytes = val[15:0];
      npie_pkg::REG_METADATA_BYTES: m_cfg.metadata_bytes = val[7:0];
      npie_pkg::REG_GUARD_FORMAT: m_cfg.guard_format = val[0];
      npie_pkg::REG_LAYOUT_MODE: m_cfg.layout_mode = val[1:0];
      npie_pkg::REG_PROTECTION_TYPE: m_cfg.protection_type = val[1:0];
      npie_pkg::REG_CHECK_ENABLES: m_cfg.check_enables = val[2:0];
      npie_pkg::REG_FIRST_REF_TAG: m_cfg.first_ref_tag = val;
      npie_pkg::REG_APP_TAG_AND_MASK: m_cfg.app_tag_and_mask = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stop offering words and wait until every expected word has come back.
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_cfg(int bb, int md, int wide, int lay, int ptype, int chk,
                           logic [31:0] iref, logic [31:0] app);
    drain();
    write_reg(npie_pkg::REG_BLOCK_BYTES, bb);
    write_reg(npie_pkg::REG_METADATA_BYTES, md);
    write_reg(npie_pkg::REG_GUARD_FORMAT, wide);
    write_reg(npie_pkg::REG_LAYOUT_MODE, lay);
    write_reg(npie_pkg::REG_PROTECTION_TYPE, ptype);
    write_reg(npie_pkg::REG_CHECK_ENABLES, chk);
    write_reg(npie_pkg::REG_FIRST_REF_TAG, iref);
    write_reg(npie_pkg::REG_APP_TAG_AND_MASK, app);
    settings_used++;
  endtask

  // Offer one word, with a random gap in front of it, until it is accepted.
  task automatic send_word(logic k, logic [7:0] b, logic cs);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    push <= 1'b1;
    kind <= k;
    in_byte <= b;
    command_start <= cs;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_words.push_back(predict_word(k, b, cs));
    words_sent++;
  endtask

  // Send one block. Verify blocks carry correct protection bytes unless
  // corrupted or partial; an escaped block carries an all-ones app tag (and, for type 3, ref tag).
  task automatic send_block(logic k, logic new_cmd, int style);
    int unsigned n;
    int unsigned st;
    int unsigned kk;
    int unsigned gl;
    int unsigned bad_at;
    logic        cs;
    logic        ek;
    logic [7:0]  b;
    if (new_cmd) start_command(k);
    n = stream_len() == 0 ? 1 : stream_len();
    if (style == STYLE_PARTIAL && n > 1) n = $urandom_range(1, n - 1);
    bad_at = $urandom_range(0, n - 1);
    gl = m_cfg.guard_format ? 8 : 2;
    for (int unsigned i = 0; i < n; i++) begin
      cs = new_cmd && i == 0;
      ek = m_kind;
      b = 8'($urandom_range(255));
      if (cfg_ok() && ek == KIND_VERIFY && style != STYLE_PARTIAL) begin
        st = field_start();
        if (m_pos >= st && m_pos - st < pi_len()) begin
          kk = m_pos - st;
          b = pi_byte(kk);
          if (style == STYLE_ESCAPE && kk >= gl &&
              (kk < gl + 2 || m_cfg.protection_type == 2'd3)) b = 8'hFF;
        end
      end
      if (style == STYLE_CORRUPT && i == bad_at) b ^= 8'($urandom_range(1, 255));
      send_word(cs ? k : logic'($urandom_range(1)), b, cs);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_rx > 0) begin
      pop <= 1'b0;
      hold_rx--;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ERROR %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    word_exp_t e;
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t ERROR no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
      if (pop && !empty) begin
        if (pending_words.size() == 0) begin
          $display("%0t ERROR unexpected word, actual byte %0h", $time, out_byte);
          errors++;
        end else begin
          e = pending_words.pop_front();
          check_field("out_byte", e.ob, out_byte);
          check_field("block_end", e.last, block_end);
          check_field("verdict", e.verdict, verdict);
          check_field("block_offset", e.offset, block_offset);
          words_checked++;
          if (e.last) verdicts_seen++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short interleaved blocks through the verdicts, with one corrupted block, the ref tag
  // wrapping past all ones, an escape of each kind and a bad configuration.
  task automatic test_directed();
    apply_cfg(10, 8, 0, 1, 1, 7, 32'hFFFF_FFFF, 32'hFFFF_1234);
    send_block(KIND_GENERATE, 1'b1, STYLE_CLEAN);
    send_block(KIND_VERIFY, 1'b1, STYLE_CLEAN);
    send_block(KIND_VERIFY, 1'b0, STYLE_CLEAN);
    send_block(KIND_VERIFY, 1'b0, STYLE_CORRUPT);
    send_block(KIND_VERIFY, 1'b0, STYLE_CLEAN);
    send_block(KIND_VERIFY, 1'b1, STYLE_ESCAPE);
    // Metadata smaller than the protection field: every block end is flagged.
    apply_cfg(10, 4, 0, 1, 2, 7, 0, 0);
    send_block(KIND_VERIFY, 1'b1, STYLE_CLEAN);
    // Type 3 escape needs an all-ones ref tag as well.
    apply_cfg(16, 16, 1, 3, 3, 3, 32'h0000_0001, 32'h0000_FFFF);
    send_block(KIND_GENERATE, 1'b1, STYLE_CLEAN);
    send_block(KIND_VERIFY, 1'b1, STYLE_ESCAPE);
    send_block(KIND_VERIFY, 1'b0, STYLE_CLEAN);
    // Largest block with type 3 plus ref check, which is rejected.
    apply_cfg(65535, 255, 1, 2, 3, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(KIND_VERIFY, 8'h5A, 1'b1);
    repeat (4) send_word(KIND_VERIFY, 8'($urandom_range(255)), 1'b0);
    send_word(KIND_VERIFY, 8'hFF, 1'b1);
    send_word(KIND_GENERATE, 8'h00, 1'b1);
  endtask

  // Separate metadata at the layout's block unit, and a wide guard whose
  // block is not a multiple of its unit.
  task automatic test_separate_layouts();
    apply_cfg(512, 8, 0, 0, 2, 7, 32'h1234_5678, 32'hFF00_5A5A);
    send_block(KIND_VERIFY, 1'b1, STYLE_CLEAN);
    apply_cfg(512, 16, 1, 2, 1, 7, 32'h8000_0000, 32'h0000_0000);
    send_word(KIND_GENERATE, 8'h11, 1'b1);
    repeat (11) send_word(KIND_GENERATE, 8'($urandom_range(255)), 1'b0);
  endtask

  // Random small configurations, mostly well-formed commands with random data.
  task automatic test_random(int items, int s_idle, int r_idle);
    int target;
    int wide;
    int md;
    int lay;
    int bb;
    int ptype;
    int chk;
    int pick;
    logic [31:0] iref;
    logic [31:0] app;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    target = words_sent + items;
    while (words_sent < target) begin
      wide = $urandom_range(1);
      md = (wide ? 16 : 8) + $urandom_range(0, 8);
      if ($urandom_range(19) == 0) md = 255;
      lay = {$urandom_range(1), 1'b1};
      bb = md + $urandom_range(0, 24);
      if (md == 255) bb = 255;
      ptype = $urandom_range(3);
      chk = $urandom_range(7);
      if (ptype == 3 && $urandom_range(3) != 0) chk &= 3;
      // Now and then an invalid layout.
      pick = $urandom_range(9);
      if (pick == 0) md = (wide ? 16 : 8) - $urandom_range(1, 8);
      else if (pick == 1) bb = $urandom_range(0, md - 1);
      iref = $urandom_range(1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 3);
      app = $urandom;
      if ($urandom_range(3) == 0) app[31:16] = 16'hFFFF;
      apply_cfg(bb, md, wide, lay, ptype, chk, iref, app);
      repeat ($urandom_range(2, 6)) begin
        pick = $urandom_range(19);
        send_block($urandom_range(3) != 0 ? KIND_VERIFY : KIND_GENERATE,
                   $urandom_range(2) == 0,
                   pick < 13 ? STYLE_CLEAN : pick < 17 ? STYLE_CORRUPT :
                   pick < 19 ? STYLE_ESCAPE : STYLE_PARTIAL);
      end
    end
  endtask

  // The receiver holds off while words keep coming, so the input stalls.
  // Then the sender pauses mid-command until every word has come back.
  task automatic test_pressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_cfg(24, 8, 0, 3, 1, 7, 32'h0000_0100, 32'hFFFF_ABCD);
    hold_rx = 300;
    send_block(KIND_VERIFY, 1'b1, STYLE_CLEAN);
    send_block(KIND_VERIFY, 1'b0, STYLE_CLEAN);
    drain();
    send_block(KIND_VERIFY, 1'b0, STYLE_CLEAN);
    send_block(KIND_GENERATE, 1'b1, STYLE_CLEAN);
  endtask

  initial begin
    m_cfg = '{block_bytes: 16'd512, metadata_bytes: 8'd8, guard_format: 1'b0,
              layout_mode: 2'd0, protection_type: 2'd1, check_enables: 3'd7,
              first_ref_tag: 32'd0, app_tag_and_mask: 32'hFFFF_0000};
    start_command(KIND_GENERATE);
    for (int i = 0; i < 16; i++) m_cap[i] = 8'h00;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 9;
    recv_idle_pct = 75;
    test_directed();
    test_separate_layouts();
    test_random(130, 9, 75);
    test_random(130, 75, 9);
    test_random(110, 0, 0);
    test_pressure();
    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d words and checked %0d, with %0d block verdicts over %0d settings.",
             words_sent, words_checked, verdicts_seen, settings_used);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0t ERROR %0d mismatches, %0d words never came back", $time, errors,
               pending_words.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
